>>> rtl/core/tqpa_pkg.sv
// ----------------------------------------------------------------------------
// tqpa_pkg
// Shared types and constants for the two-queue priority aging arbiter.
// ----------------------------------------------------------------------------
package tqpa_pkg;

   localparam int TICK_W      = 16;
   localparam int IN_ID_W     = 16;
   localparam int OUT_ID_W    = 16;
   localparam int COUNT_W     = 5;
   localparam int AGING_W     = 16;
   localparam int THRESH_W    = 5;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam int DEFAULT_QUEUE_DEPTH = 16;
   localparam int DEFAULT_ID_WIDTH    = 16;

   localparam logic [AGING_W-1:0]  AGING_LIMIT_RESET     = 16'd10;
   localparam logic [THRESH_W-1:0] DEPTH_THRESHOLD_RESET = 5'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_AGING_LIMIT     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEPTH_THRESHOLD = 2'd1;

   localparam logic [1:0] GRANT_NONE = 2'd0;
   localparam logic [1:0] GRANT_HIGH = 2'd1;
   localparam logic [1:0] GRANT_LOW  = 2'd2;

   typedef struct packed {
      logic               push_high;
      logic [IN_ID_W-1:0] high_id;
      logic               push_low;
      logic [IN_ID_W-1:0] low_id;
   } req_type;

   typedef struct packed {
      logic [1:0]          grant_kind;
      logic [OUT_ID_W-1:0] grant_id;
      logic [TICK_W-1:0]   grant_wait;
      logic [COUNT_W-1:0]  high_count;
      logic [COUNT_W-1:0]  low_count;
      logic                high_dropped;
      logic                low_dropped;
   } rsp_type;

endpackage

>>> rtl/core/two_queue_priority_aging_arbiter_unit.sv
// ----------------------------------------------------------------------------
// two_queue_priority_aging_arbiter_unit
// Flow: a transaction is registered in the input register and then moves into
// the result register that drives rsp when that register is free.
// Throughput: one transaction per cycle while rsp is not stalled; the only loop
// is the queue pointer update, which closes with the head entry prefetched.
// Reset (synchronous): queues empty, tick count 0, aging_limit 10,
// depth_threshold 3; no clearing pass, the block accepts at once.
// ----------------------------------------------------------------------------
module two_queue_priority_aging_arbiter_unit
   import tqpa_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH,
   parameter int ID_WIDTH    = DEFAULT_ID_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

   logic                in_valid_ff;
   req_type             in_data_ff;
   logic                rsp_valid_ff;
   rsp_type             rsp_data_ff;
   logic [TICK_W-1:0]   tick_ff;
   logic [AGING_W-1:0]  aging_limit_ff;
   logic [THRESH_W-1:0] depth_threshold_ff;

   logic                advance, proc;
   logic [31:0]         high_id_ext, low_id_ext;
   logic [FILL_W-1:0]   high_fill, low_fill;
   logic [ID_WIDTH-1:0] high_head_id, low_head_id;
   logic [TICK_W-1:0]   high_head_stamp, low_head_stamp;
   logic                high_drop, low_drop, pop_high, pop_low;
   rsp_type             rsp_in;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign proc      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

   assign high_id_ext = 32'(in_data_ff.high_id);
   assign low_id_ext  = 32'(in_data_ff.low_id);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         tick_ff      <= '0;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= in_valid_ff;
         end
         if (proc) begin
            tick_ff <= tick_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
      if (proc) begin
         rsp_data_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         aging_limit_ff     <= AGING_LIMIT_RESET;
         depth_threshold_ff <= DEPTH_THRESHOLD_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_AGING_LIMIT: begin
               aging_limit_ff <= csr_wdata[AGING_W-1:0];
            end
            CSR_DEPTH_THRESHOLD: begin
               depth_threshold_ff <= csr_wdata[THRESH_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   tqpa_queue #(
      .DEPTH (QUEUE_DEPTH),
      .ID_W  (ID_WIDTH)
   ) u_high_queue (
      .clock      (clock),
      .reset      (reset),
      .enable     (proc),
      .push       (in_data_ff.push_high),
      .push_id    (high_id_ext[ID_WIDTH-1:0]),
      .push_stamp (tick_ff),
      .pop        (pop_high),
      .fill_eff   (high_fill),
      .dropped    (high_drop),
      .head_id    (high_head_id),
      .head_stamp (high_head_stamp)
   );

   tqpa_queue #(
      .DEPTH (QUEUE_DEPTH),
      .ID_W  (ID_WIDTH)
   ) u_low_queue (
      .clock      (clock),
      .reset      (reset),
      .enable     (proc),
      .push       (in_data_ff.push_low),
      .push_id    (low_id_ext[ID_WIDTH-1:0]),
      .push_stamp (tick_ff),
      .pop        (pop_low),
      .fill_eff   (low_fill),
      .dropped    (low_drop),
      .head_id    (low_head_id),
      .head_stamp (low_head_stamp)
   );

   tqpa_arbiter #(
      .FILL_W (FILL_W),
      .ID_W   (ID_WIDTH)
   ) u_arbiter (
      .tick            (tick_ff),
      .aging_limit     (aging_limit_ff),
      .depth_threshold (depth_threshold_ff),
      .high_fill       (high_fill),
      .high_head_id    (high_head_id),
      .high_head_stamp (high_head_stamp),
      .high_drop       (high_drop),
      .low_fill        (low_fill),
      .low_head_id     (low_head_id),
      .low_head_stamp  (low_head_stamp),
      .low_drop        (low_drop),
      .pop_high        (pop_high),
      .pop_low         (pop_low),
      .rsp             (rsp_in)
   );

`ifndef SYNTHESIS
   a_single_grant: assert property (@(posedge clock) disable iff (reset)
      !(pop_high && pop_low))
      else $error("both queues granted in one transaction");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      (!pop_low || low_fill != '0) && (!pop_high || high_fill != '0))
      else $error("grant from an empty queue");

   a_tick_step: assert property (@(posedge clock) disable iff (reset)
      proc |=> tick_ff == $past(tick_ff) + 1'b1)
      else $error("tick count did not advance with transaction");

   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> rsp_valid_ff)
      else $error("stalled result lost");
`endif

endmodule

>>> rtl/core/tqpa_queue.sv
// ----------------------------------------------------------------------------
// tqpa_queue
// Bounded FIFO of IDs with arrival stamps; head entry is prefetched into a
// register, with bypass for a push into an empty queue.
// ----------------------------------------------------------------------------
module tqpa_queue
   import tqpa_pkg::*;
#(
   parameter int DEPTH = DEFAULT_QUEUE_DEPTH,
   parameter int ID_W  = DEFAULT_ID_WIDTH,
   localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int FILL_W = $clog2(DEPTH + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  logic              push,
   input  logic [ID_W-1:0]   push_id,
   input  logic [TICK_W-1:0] push_stamp,
   input  logic              pop,
   output logic [FILL_W-1:0] fill_eff,
   output logic              dropped,
   output logic [ID_W-1:0]   head_id,
   output logic [TICK_W-1:0] head_stamp
);

   localparam int SUM_W = PTR_W + 1;

   logic [PTR_W-1:0]  head_ff, head_in, head_inc;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [ID_W-1:0]   mem_id [DEPTH];
   logic [TICK_W-1:0] mem_stamp [DEPTH];
   logic [ID_W-1:0]   rd_id_ff;
   logic [TICK_W-1:0] rd_stamp_ff;
   logic              full, accepted;
   logic [SUM_W-1:0]  wr_sum;
   logic [PTR_W-1:0]  wr_addr;

   assign full     = (fill_ff == FILL_W'(DEPTH));
   assign accepted = push && !full;
   assign dropped  = push && full;
   assign fill_eff = fill_ff + FILL_W'(accepted);

   assign wr_sum  = SUM_W'(head_ff) + SUM_W'(fill_ff[PTR_W-1:0]);
   assign wr_addr = (wr_sum >= SUM_W'(DEPTH)) ? PTR_W'(wr_sum - SUM_W'(DEPTH))
                                              : wr_sum[PTR_W-1:0];

   assign head_inc = (head_ff == PTR_W'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign head_in  = pop ? head_inc : head_ff;
   assign fill_in  = fill_eff - FILL_W'(pop);

   assign head_id    = (fill_ff == '0) ? push_id : rd_id_ff;
   assign head_stamp = (fill_ff == '0) ? push_stamp : rd_stamp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         fill_ff <= '0;
      end else if (enable) begin
         head_ff <= head_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         if (accepted) begin
            mem_id[wr_addr]    <= push_id;
            mem_stamp[wr_addr] <= push_stamp;
         end
         if (accepted && (wr_addr == head_in)) begin
            rd_id_ff    <= push_id;
            rd_stamp_ff <= push_stamp;
         end else begin
            rd_id_ff    <= mem_id[head_in];
            rd_stamp_ff <= mem_stamp[head_in];
         end
      end
   end

endmodule

>>> rtl/core/tqpa_arbiter.sv
// ----------------------------------------------------------------------------
// tqpa_arbiter
// Grant decision between the two queue heads and result assembly.
// ----------------------------------------------------------------------------
module tqpa_arbiter
   import tqpa_pkg::*;
#(
   parameter int FILL_W = 5,
   parameter int ID_W   = DEFAULT_ID_WIDTH
) (
   input  logic [TICK_W-1:0]   tick,
   input  logic [AGING_W-1:0]  aging_limit,
   input  logic [THRESH_W-1:0] depth_threshold,
   input  logic [FILL_W-1:0]   high_fill,
   input  logic [ID_W-1:0]     high_head_id,
   input  logic [TICK_W-1:0]   high_head_stamp,
   input  logic                high_drop,
   input  logic [FILL_W-1:0]   low_fill,
   input  logic [ID_W-1:0]     low_head_id,
   input  logic [TICK_W-1:0]   low_head_stamp,
   input  logic                low_drop,
   output logic                pop_high,
   output logic                pop_low,
   output rsp_type             rsp
);

   logic [TICK_W-1:0] low_wait;
   logic              low_wins;
   logic [ID_W-1:0]   gid;
   logic [TICK_W-1:0] gstamp;
   logic [31:0]       gid_ext;
   logic [31:0]       high_left, low_left;

   assign low_wait = tick - low_head_stamp;
   assign low_wins = (low_fill != '0) &&
                     ((high_fill == '0) ||
                      (32'(low_fill) >= 32'(depth_threshold)) ||
                      (low_wait >= aging_limit));

   assign pop_low  = low_wins;
   assign pop_high = !low_wins && (high_fill != '0);

   assign gid     = pop_low ? low_head_id : high_head_id;
   assign gstamp  = pop_low ? low_head_stamp : high_head_stamp;
   assign gid_ext = 32'(gid);

   assign high_left = 32'(high_fill - FILL_W'(pop_high));
   assign low_left  = 32'(low_fill - FILL_W'(pop_low));

   always_comb begin
      rsp.grant_kind   = GRANT_NONE;
      rsp.grant_id     = '0;
      rsp.grant_wait   = '0;
      if (pop_low || pop_high) begin
         rsp.grant_kind = pop_low ? GRANT_LOW : GRANT_HIGH;
         rsp.grant_id   = gid_ext[OUT_ID_W-1:0];
         rsp.grant_wait = tick - gstamp;
      end
      rsp.high_count   = high_left[COUNT_W-1:0];
      rsp.low_count    = low_left[COUNT_W-1:0];
      rsp.high_dropped = high_drop;
      rsp.low_dropped  = low_drop;
   end

endmodule
